@@ sv/life_automaton_torus_unit_macros.svh @@
// ----------------------------------------------------------------------------
// life_automaton_torus_unit_macros
// Assertion macros used by the life automaton top module.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_TORUS_UNIT_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_UNIT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define LTA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lta same-cycle check failed");

// antecedent holds, consequent holds in the next cycle
`define LTA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lta next-cycle check failed");

`endif

@@ sv/lta_pkg.sv @@
// ----------------------------------------------------------------------------
// lta_pkg
// Word types and opcodes for the toroidal life automaton.
// ----------------------------------------------------------------------------
package lta_pkg;

    // opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // field widths
    localparam int IDX_W = 6;

    // input word
    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic             cell_in;
    } lta_in_t;

    // result word
    typedef struct packed {
        logic cell_out;
        logic done_res;
    } lta_out_t;

    // cell access command broadcast to every row cell
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             val;
    } lta_cmd_t;

endpackage

@@ sv/lta_row_cell.sv @@
// ----------------------------------------------------------------------------
// lta_row_cell
// One board row: loads from its neighbor when the chain shifts, otherwise
// takes single-cell writes and answers single-cell reads at its row index.
// ----------------------------------------------------------------------------
module lta_row_cell #(
    parameter int GRID_SIZE = 64,
    parameter int CELL_IDX  = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic [GRID_SIZE-1:0] shift_in,
    input  lta_pkg::lta_cmd_t    cmd,
    output logic [GRID_SIZE-1:0] row_out,
    output logic                 rd_bit
);
    localparam int IW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int AW = ((IW > lta_pkg::IDX_W) ? IW : lta_pkg::IDX_W) + 1;

    logic [GRID_SIZE-1:0] row_reg;
    logic [AW-1:0]        row_ext;
    logic [AW-1:0]        col_ext;
    logic                 row_hit;
    logic                 col_ok;
    logic [IW-1:0]        col_sel;

    // address decode
    assign row_ext = AW'(cmd.row);
    assign col_ext = AW'(cmd.col);
    assign row_hit = (row_ext == AW'(CELL_IDX));
    assign col_ok  = (col_ext < AW'(GRID_SIZE));
    assign col_sel = col_ext[IW-1:0];

    // row storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else if (shift_en) begin
            row_reg <= shift_in;
        end else if (cmd.wr_en && row_hit && col_ok) begin
            row_reg[col_sel] <= cmd.val;
        end
    end

    // read tap
    assign rd_bit  = row_hit && col_ok && row_reg[col_sel];
    assign row_out = row_reg;

endmodule

@@ sv/lta_rule.sv @@
// ----------------------------------------------------------------------------
// lta_rule
// Next-generation value of one row from the rows above, at and below it,
// with columns wrapping around the board edge.
// ----------------------------------------------------------------------------
module lta_rule #(
    parameter int GRID_SIZE = 64
) (
    input  logic [GRID_SIZE-1:0] row_up,
    input  logic [GRID_SIZE-1:0] row_mid,
    input  logic [GRID_SIZE-1:0] row_dn,
    output logic [GRID_SIZE-1:0] row_new
);
    genvar c;
    generate
        for (c = 0; c < GRID_SIZE; c++) begin : g_col
            localparam int CL = (c == 0) ? GRID_SIZE - 1 : c - 1;
            localparam int CR = (c == GRID_SIZE - 1) ? 0 : c + 1;
            logic [3:0] nbr;

            // live neighbor count
            assign nbr = 4'(row_up[CL]) + 4'(row_up[c]) + 4'(row_up[CR])
                       + 4'(row_mid[CL]) + 4'(row_mid[CR])
                       + 4'(row_dn[CL]) + 4'(row_dn[c]) + 4'(row_dn[CR]);

            // survive on two or three, birth on three
            assign row_new[c] = (nbr == 4'd3) || (row_mid[c] && (nbr == 4'd2));
        end
    endgenerate

endmodule

@@ sv/life_automaton_torus_unit.sv @@
// ----------------------------------------------------------------------------
// life_automaton_torus_unit
// Conway life board on a torus, held as a ring of row cells.
//
//   channel | ports                        | word
//   input   | s_valid s_ready s_payload    | lta_in_t  (opcode, row, col, cell)
//   result  | m_valid m_ready m_payload    | lta_out_t (cell_out, done_res)
//
// Non-step words finish on acceptance; the result is registered and valid in the next cycle.
// A step word rotates the row chain once around, one row through the rule
// unit per cycle, and the result word is posted once the last row is done.
// Reset clears every board cell at once; no clearing pass is needed.
// A held result stalls new input until it is taken or taken in that cycle.
// ----------------------------------------------------------------------------
module life_automaton_torus_unit #(
    parameter int GRID_SIZE = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lta_pkg::lta_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output lta_pkg::lta_out_t m_payload
);
    localparam int IW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } state_t;

    state_t               state_reg;
    logic [IW-1:0]        cnt_reg;
    logic [GRID_SIZE-1:0] prev_reg;
    logic [GRID_SIZE-1:0] save0_reg;
    logic                 m_valid_reg;
    lta_pkg::lta_out_t    out_reg;

    logic                 accept;
    logic                 last_row;
    logic                 shift_en;
    lta_pkg::lta_cmd_t    cmd;
    logic [GRID_SIZE-1:0] row_q [GRID_SIZE];
    logic [GRID_SIZE-1:0] rd_bits;
    logic [GRID_SIZE-1:0] row_dn;
    logic [GRID_SIZE-1:0] row_new;

    // handshake
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // cell command
    assign cmd.wr_en = accept && (s_payload.opcode == lta_pkg::OP_WRITE);
    assign cmd.row   = s_payload.row_index;
    assign cmd.col   = s_payload.col_index;
    assign cmd.val   = s_payload.cell_in;

    assign shift_en  = (state_reg == ST_STEP);
    assign last_row  = (cnt_reg == IW'(GRID_SIZE - 1));

    // ring of row cells, each shifting toward row zero
    genvar i;
    generate
        for (i = 0; i < GRID_SIZE; i++) begin : g_row
            logic [GRID_SIZE-1:0] feed;
            if (i == GRID_SIZE - 1) begin : g_tail
                assign feed = row_new;
            end else begin : g_body
                assign feed = row_q[i + 1];
            end
            lta_row_cell #(
                .GRID_SIZE (GRID_SIZE),
                .CELL_IDX  (i)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .shift_in (feed),
                .cmd      (cmd),
                .row_out  (row_q[i]),
                .rd_bit   (rd_bits[i])
            );
        end
    endgenerate

    // row below wraps to the saved old row zero on the last row
    assign row_dn = last_row ? save0_reg : row_q[1];

    lta_rule #(
        .GRID_SIZE (GRID_SIZE)
    ) u_rule (
        .row_up  (prev_reg),
        .row_mid (row_q[0]),
        .row_dn  (row_dn),
        .row_new (row_new)
    );

    // control and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            out_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_payload.opcode == lta_pkg::OP_STEP) begin
                            state_reg   <= ST_STEP;
                            cnt_reg     <= '0;
                            m_valid_reg <= 1'b0;
                        end else begin
                            m_valid_reg      <= 1'b1;
                            out_reg.done_res <= 1'b1;
                            out_reg.cell_out <= (s_payload.opcode == lta_pkg::OP_READ)
                                                && (|rd_bits);
                        end
                    end else if (m_ready) begin
                        // held word taken
                        m_valid_reg <= 1'b0;
                    end
                end
                ST_STEP: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_row) begin
                        state_reg        <= ST_IDLE;
                        m_valid_reg      <= 1'b1;
                        out_reg.done_res <= 1'b1;
                        out_reg.cell_out <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // wrap rows: old last row above row zero, old row zero below the last row
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_reg  <= row_q[GRID_SIZE - 1];
            save0_reg <= row_q[0];
        end else if (shift_en) begin
            prev_reg  <= row_q[0];
        end
    end

`include "life_automaton_torus_unit_macros.svh"

    `LTA_ASSERT_SAME(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `LTA_ASSERT_SAME(a_step_no_result, aclk, aresetn, state_reg == ST_STEP, !m_valid_reg)
    `LTA_ASSERT_NEXT(a_step_start, aclk, aresetn,
        accept && (s_payload.opcode == lta_pkg::OP_STEP), state_reg == ST_STEP)
    `LTA_ASSERT_NEXT(a_step_done, aclk, aresetn,
        (state_reg == ST_STEP) && last_row, m_valid_reg && out_reg.done_res)

endmodule

@@ dv/tb_life_automaton_torus_unit.sv @@
// ----------------------------------------------------------------------------
// tb_life_automaton_torus_unit
// Self-checking bench for the toroidal life board. Writes, reads, generation
// steps and the unused opcode are driven over the valid/ready input channel.
// A board tracker mirrors every accepted word and predicts each result word,
// including full generation steps with edge wrap. Both channels idle at
// random in the first two of three phases, with one long result hold-off and
// an input pause after the first phase until all results have drained.
// ----------------------------------------------------------------------------
module tb_life_automaton_torus_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_N        = 64;
    localparam int TOTAL_ITEMS   = 825;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // tracks the board and the result words still owed by the block
    class board_tracker;
        bit [GRID_N-1:0]   board [GRID_N];
        lta_pkg::lta_out_t pending_results [$];
        int                errors;

        function new();
            foreach (board[r]) board[r] = '0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // one generation under the life rule, neighbours wrap at the edges
        function void advance_generation();
            bit [GRID_N-1:0] nxt [GRID_N];
            int n;
            for (int r = 0; r < GRID_N; r++) begin
                for (int c = 0; c < GRID_N; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0) begin
                                n += board[(r + dr + GRID_N) % GRID_N]
                                          [(c + dc + GRID_N) % GRID_N];
                            end
                        end
                    end
                    if (board[r][c])
                        nxt[r][c] = (n == 2 || n == 3);
                    else
                        nxt[r][c] = (n == 3);
                end
            end
            foreach (board[r]) board[r] = nxt[r];
        endfunction

        // apply an accepted input word and queue its result word
        function void note_word(lta_pkg::lta_in_t w);
            lta_pkg::lta_out_t res;
            bit                on_board;
            on_board = (int'(w.row_index) < GRID_N) && (int'(w.col_index) < GRID_N);
            res.cell_out = 1'b0;
            res.done_res = 1'b1;
            case (w.opcode)
                lta_pkg::OP_WRITE: begin
                    if (on_board) board[w.row_index][w.col_index] = w.cell_in;
                end
                lta_pkg::OP_STEP: begin
                    advance_generation();
                end
                lta_pkg::OP_READ: begin
                    if (on_board) res.cell_out = board[w.row_index][w.col_index];
                end
                default: begin
                end
            endcase
            pending_results.push_back(res);
        endfunction

        // compare a result word with the oldest prediction
        function void check_word(lta_pkg::lta_out_t got);
            lta_pkg::lta_out_t exp_w;
            if (pending_results.size() == 0) begin
                $error("result word with no prediction: cell_out %0b done_res %0b",
                       got.cell_out, got.done_res);
                errors++;
                return;
            end
            exp_w = pending_results.pop_front();
            if (got.cell_out !== exp_w.cell_out) begin
                $error("cell_out mismatch: expected %0b, actual %0b",
                       exp_w.cell_out, got.cell_out);
                errors++;
            end
            if (got.done_res !== exp_w.done_res) begin
                $error("done_res mismatch: expected %0b, actual %0b",
                       exp_w.done_res, got.done_res);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    lta_pkg::lta_in_t  s_payload;
    logic              m_valid;
    logic              m_ready;
    lta_pkg::lta_out_t m_payload;

    board_tracker tracker = new();

    int items_sent;
    int results_seen;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_done;
    bit reset_done;

    life_automaton_torus_unit #(
        .GRID_SIZE(GRID_N)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[life_automaton_torus_unit] ERROR");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_word(m_payload);
            results_seen++;
        end
    end

    // result side ready, with one long hold-off
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        wait (reset_done);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready   = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic lta_pkg::lta_in_t mk_word(logic [1:0] op, logic [5:0] row,
                                                 logic [5:0] col, logic val);
        lta_pkg::lta_in_t w;
        w.opcode    = op;
        w.row_index = row;
        w.col_index = col;
        w.cell_in   = val;
        return w;
    endfunction

    // origin biased toward the wrap seam
    function automatic logic [5:0] pick_origin();
        if ($urandom_range(99) < 30)
            return 6'(62 + $urandom_range(3));
        return 6'($urandom_range(63));
    endfunction

    // offer one input word, entered and left at a falling edge
    task automatic send_word(lta_pkg::lta_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        tracker.note_word(w);
        items_sent++;
        @(negedge aclk);
    endtask

    // random fields, random opcode
    task automatic send_noise();
        send_word(mk_word(2'($urandom_range(3)), 6'($urandom_range(63)),
                          6'($urandom_range(63)), 1'($urandom_range(1))));
    endtask

    // drop valid and wait for every owed result word
    task automatic drain_results();
        s_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // seed a random patch, run some generations, probe around it
    task automatic run_patch(bit broken);
        logic [5:0] r0;
        logic [5:0] c0;
        int k;
        int n_wr;
        int n_steps;
        r0 = pick_origin();
        c0 = pick_origin();
        k  = $urandom_range(3, 5);
        n_wr = broken ? $urandom_range(1, k * k - 1) : k * k;
        for (int i = 0; i < n_wr; i++) begin
            send_word(mk_word(lta_pkg::OP_WRITE, r0 + 6'(i / k), c0 + 6'(i % k),
                              1'($urandom_range(99) < 45)));
        end
        n_steps = broken ? $urandom_range(0, 1) : $urandom_range(1, 3);
        for (int i = 0; i < n_steps; i++) begin
            send_word(mk_word(lta_pkg::OP_STEP, 6'($urandom_range(63)),
                              6'($urandom_range(63)), 1'($urandom_range(1))));
        end
        for (int i = 0; i < 8; i++) begin
            send_word(mk_word(lta_pkg::OP_READ, r0 - 6'd1 + 6'($urandom_range(k + 1)),
                              c0 - 6'd1 + 6'($urandom_range(k + 1)),
                              1'($urandom_range(1))));
        end
    endtask

    // main stimulus
    initial begin
        int  pick;
        int  phase;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_payload  = '0;
        items_sent = 0;
        results_seen  = 0;
        reset_done    = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 78;
        phase = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn    = 1'b1;
        reset_done = 1'b1;

        // four corners alive: a block across both seams
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd0,  6'd0,  1'b1));
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1));
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd0,  6'd63, 1'b1));
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd63, 6'd0,  1'b1));
        send_word(mk_word(lta_pkg::OP_READ,  6'd63, 6'd63, 1'b1));
        send_word(mk_word(lta_pkg::OP_READ,  6'd1,  6'd1,  1'b0));
        send_word(mk_word(lta_pkg::OP_STEP,  6'd0,  6'd0,  1'b0));
        send_word(mk_word(lta_pkg::OP_READ,  6'd0,  6'd0,  1'b0));
        send_word(mk_word(lta_pkg::OP_READ,  6'd63, 6'd63, 1'b1));
        // unused opcode leaves the board alone
        send_word(mk_word(OP_UNUSED, 6'd63, 6'd63, 1'b1));
        send_word(mk_word(OP_UNUSED, 6'd0,  6'd0,  1'b0));
        send_word(mk_word(lta_pkg::OP_READ,  6'd63, 6'd0,  1'b0));
        // remove one corner: it is born again from three neighbours
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd0,  6'd0,  1'b0));
        send_word(mk_word(lta_pkg::OP_STEP,  6'd63, 6'd63, 1'b1));
        send_word(mk_word(lta_pkg::OP_READ,  6'd0,  6'd0,  1'b1));
        // blinker across the column seam
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd32, 6'd63, 1'b1));
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd32, 6'd0,  1'b1));
        send_word(mk_word(lta_pkg::OP_WRITE, 6'd32, 6'd1,  1'b1));
        send_word(mk_word(lta_pkg::OP_STEP,  6'd32, 6'd0,  1'b0));
        send_word(mk_word(lta_pkg::OP_READ,  6'd31, 6'd0,  1'b0));
        send_word(mk_word(lta_pkg::OP_READ,  6'd33, 6'd0,  1'b1));
        send_word(mk_word(lta_pkg::OP_READ,  6'd32, 6'd63, 1'b0));
        send_word(mk_word(lta_pkg::OP_STEP,  6'd0,  6'd32, 1'b1));
        send_word(mk_word(lta_pkg::OP_READ,  6'd32, 6'd63, 1'b1));
        send_word(mk_word(lta_pkg::OP_READ,  6'd31, 6'd0,  1'b0));

        // random part in three phases, idling in the first two
        while (items_sent < TOTAL_ITEMS) begin
            if (phase == 0 && items_sent >= TOTAL_ITEMS / 3) begin
                drain_results();
                phase = 1;
                send_idle_pct = 78;
                recv_idle_pct = 27;
            end else if (phase == 1 && items_sent >= (2 * TOTAL_ITEMS) / 3) begin
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                run_patch(1'b0);
            end else if (pick < 85) begin
                send_noise();
            end else if (pick < 95) begin
                run_patch(1'b1);
            end else begin
                repeat ($urandom_range(2, 4)) begin
                    send_word(mk_word(lta_pkg::OP_STEP, pick_origin(), pick_origin(),
                                      1'($urandom_range(1))));
                end
                repeat (4) send_word(mk_word(lta_pkg::OP_READ, pick_origin(),
                                             pick_origin(), 1'($urandom_range(1))));
            end
        end

        // drain, then watch for stray result words
        drain_results();
        repeat (GRID_N + 8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("[life_automaton_torus_unit] OK");
        end else begin
            $display("[life_automaton_torus_unit] ERROR");
        end
        $finish;
    end

endmodule
